/* rtl/sooc_pkg.sv */
package sooc_pkg;

    // Element widths in bytes. The min-argmin width can be set from 4 to 16.
    localparam int CostElemBytes   = 4;
    localparam int ArgminElemBytes = 8;

    // An element width up to 16 bytes fits in five bits.
    localparam int WidthBits = 5;

    localparam int KindBits  = 3;
    localparam int AddrBits  = 64;
    localparam int CountBits = 16;

    // Stride times width, and (count - 1) times stride.
    localparam int StepBits = CountBits + WidthBits;
    localparam int ProdBits = 2 * CountBits;
    localparam int SpanBits = ProdBits + WidthBits;

    // Bit positions inside the input tdata word.
    localparam int BaseLsb   = 0;
    localparam int CountLsb  = BaseLsb + AddrBits;
    localparam int StrideLsb = CountLsb + CountBits;
    localparam int BeginLsb  = StrideLsb + CountBits;
    localparam int EndLsb    = BeginLsb + AddrBits;
    localparam int InDataBits  = EndLsb + AddrBits;
    localparam int OutDataBits = 8;

    typedef enum logic [KindBits-1:0] {
        KIND_R2_MIN     = 3'd0,
        KIND_R2_ARGMIN  = 3'd1,
        KIND_R3_MIN     = 3'd2,
        KIND_R3_ARGMIN  = 3'd3,
        KIND_VEC_ADD    = 3'd4,
        KIND_PROJECT    = 3'd5,
        KIND_MAP3_PROJ  = 3'd6,
        KIND_BATCH      = 3'd7
    } t_kind;

    function automatic logic [WidthBits-1:0] elem_width(input t_kind kind);
        logic [WidthBits-1:0] w;
        case (kind) inside
            KIND_R2_ARGMIN, KIND_R3_ARGMIN, KIND_MAP3_PROJ: w = WidthBits'(ArgminElemBytes);
            default:                                        w = WidthBits'(CostElemBytes);
        endcase
        return w;
    endfunction

    function automatic logic is_reduce(input t_kind kind);
        logic r;
        case (kind) inside
            KIND_R2_MIN, KIND_R2_ARGMIN, KIND_R3_MIN, KIND_R3_ARGMIN: r = 1'b1;
            default:                                                  r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/strided_output_overlap_check.sv */
// Channel   Direction  Ports                Contents
// s_axis    in         tdata[223:0], tuser  output description and byte range
// m_axis    out        tdata[7:0]           overlap answer in bit 0
//
// A transaction goes from acceptance through decode, the span check and the element scan
// to the result state. The scan stops early on a hit or once an element starts at or
// past the range end. A description rejected at decode skips the span check and the scan;
// one rejected on its span skips the scan. The element scan is the limit: one pair of 64-bit
// address adders and compares visits one element per cycle.
// Reset is synchronous and active low; it clears the sequencer and the output valid flag.
// The input is ready only while the sequencer is idle. A stalled result waits in
// the output register, and the next transaction can be taken while it waits.
module strided_output_overlap_check (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // out_base[63:0], out_count[79:64], out_stride[95:80],
    // range_begin[159:96], range_end[223:160]
    input  logic [sooc_pkg::InDataBits-1:0]  i_s_axis_tdata,
    // cmd[2:0]
    input  logic [sooc_pkg::KindBits-1:0]    i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // overlaps[0], zeros above
    output logic [sooc_pkg::OutDataBits-1:0] o_m_axis_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SPAN,
        S_SCAN,
        S_RESULT
    } t_state;

    t_state                             r_state;
    sooc_pkg::t_kind                    r_kind;
    logic [sooc_pkg::AddrBits-1:0]      r_base;
    logic [sooc_pkg::CountBits-1:0]     r_count;
    logic [sooc_pkg::CountBits-1:0]     r_stride;
    logic [sooc_pkg::AddrBits-1:0]      r_begin;
    logic [sooc_pkg::AddrBits-1:0]      r_end;
    logic [sooc_pkg::WidthBits-1:0]     r_width;
    logic [sooc_pkg::StepBits-1:0]      r_step;
    logic [sooc_pkg::ProdBits-1:0]      r_prod;
    logic [sooc_pkg::AddrBits-1:0]      r_room;
    logic [sooc_pkg::AddrBits-1:0]      r_addr;
    logic [sooc_pkg::AddrBits-1:0]      r_addr_end;
    logic [sooc_pkg::CountBits-1:0]     r_left;
    logic                               r_result;
    logic                               r_out_valid;
    logic                               r_out_overlaps;

    logic                               in_fire;
    logic                               out_free;
    sooc_pkg::t_kind                    in_kind;
    logic [sooc_pkg::AddrBits:0]        base_sum;
    logic                               reject;
    logic [sooc_pkg::SpanBits-1:0]      span_bytes;
    logic                               addr_below_end;
    logic                               hit;
    logic [sooc_pkg::AddrBits-1:0]      n_addr;
    logic [sooc_pkg::AddrBits-1:0]      n_addr_end;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign in_kind         = sooc_pkg::t_kind'(i_s_axis_tuser);

    // The base overflows when base + width carries out of 64 bits.
    assign base_sum = {1'b0, r_base} + (sooc_pkg::AddrBits + 1)'(r_width);
    assign reject   = (r_kind == sooc_pkg::KIND_BATCH) || (r_begin > r_end) ||
                      (r_base == '0) || (r_count == '0) || (r_stride == '0) ||
                      base_sum[sooc_pkg::AddrBits];

    // (count-1)*stride > room/width is the same test as (count-1)*stride*width > room.
    assign span_bytes = sooc_pkg::SpanBits'(r_prod) * sooc_pkg::SpanBits'(r_width);

    assign addr_below_end = r_addr < r_end;
    assign hit            = addr_below_end && (r_begin < r_addr_end);
    assign n_addr         = r_addr + sooc_pkg::AddrBits'(r_step);
    assign n_addr_end     = r_addr_end + sooc_pkg::AddrBits'(r_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_RESULT) && out_free) begin
                r_out_valid    <= 1'b1;
                r_out_overlaps <= r_result;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_kind  <= in_kind;
                        r_base  <= i_s_axis_tdata[sooc_pkg::BaseLsb +: sooc_pkg::AddrBits];
                        r_begin <= i_s_axis_tdata[sooc_pkg::BeginLsb +: sooc_pkg::AddrBits];
                        r_end   <= i_s_axis_tdata[sooc_pkg::EndLsb +: sooc_pkg::AddrBits];
                        r_width <= sooc_pkg::elem_width(in_kind);
                        // Single-result kinds write one element.
                        if (sooc_pkg::is_reduce(in_kind)) begin
                            r_count  <= sooc_pkg::CountBits'(1);
                            r_stride <= sooc_pkg::CountBits'(1);
                        end else begin
                            r_count  <=
                                i_s_axis_tdata[sooc_pkg::CountLsb +: sooc_pkg::CountBits];
                            r_stride <=
                                i_s_axis_tdata[sooc_pkg::StrideLsb +: sooc_pkg::CountBits];
                        end
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_prod <= sooc_pkg::ProdBits'(r_count - sooc_pkg::CountBits'(1)) *
                              sooc_pkg::ProdBits'(r_stride);
                    r_step <= sooc_pkg::StepBits'(r_stride) * sooc_pkg::StepBits'(r_width);
                    r_room <= ~r_base - sooc_pkg::AddrBits'(r_width);
                    if (reject) begin
                        r_result <= 1'b1;
                        r_state  <= S_RESULT;
                    end else begin
                        r_state <= S_SPAN;
                    end
                end
                S_SPAN: begin
                    r_addr     <= r_base;
                    r_addr_end <= r_base + sooc_pkg::AddrBits'(r_width);
                    r_left     <= r_count;
                    if (sooc_pkg::AddrBits'(span_bytes) > r_room) begin
                        r_result <= 1'b1;
                        r_state  <= S_RESULT;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Addresses only grow, so once one reaches the end no later one hits.
                    if (hit) begin
                        r_result <= 1'b1;
                        r_state  <= S_RESULT;
                    end else if ((r_left == sooc_pkg::CountBits'(1)) || !addr_below_end) begin
                        r_result <= 1'b0;
                        r_state  <= S_RESULT;
                    end else begin
                        r_addr     <= n_addr;
                        r_addr_end <= n_addr_end;
                        r_left     <= r_left - sooc_pkg::CountBits'(1);
                    end
                end
                S_RESULT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(sooc_pkg::OutDataBits - 1){1'b0}}, r_out_overlaps};

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_s_axis_tready)
        else $error("input taken while a transaction is in progress");

    a_scan_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_left != '0))
        else $error("element scan running with no elements left");

    a_scan_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_addr_end == r_addr + sooc_pkg::AddrBits'(r_width)))
        else $error("element end address out of step with its start");

endmodule
